>>> rtl/assert_macros.svh
// assertion macros used by the rtl controller dda_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// concurrent check on the rising clock, off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// concurrent check that a condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/dda_pkg.sv
// shared constants and types of the dda line pixel generator
package dda_pkg;

  localparam int CoordBits  = 10;
  localparam int FracBits   = 16;
  localparam int AccBits    = CoordBits + FracBits + 1;
  localparam int IncBits    = FracBits + 2;
  localparam int LeftBits   = CoordBits + 1;
  localparam int NumBits    = CoordBits + FracBits;
  localparam int DivCntBits = $clog2(NumBits + 1);

  localparam logic [3:0] ColorHoriz = 4'd10;
  localparam logic [3:0] ColorFirst = 4'd4;
  localparam logic [3:0] ColorRest  = 4'd15;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_line;
    logic step_px;
    logic div_step;
  } dda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic div_last;
  } dda_status_t;

endpackage

>>> rtl/dda_if.sv
// valid/ready channels for input words and pixel words
interface dda_in_if import dda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_e                  op;
  logic [CoordBits-1:0] x_begin;
  logic [CoordBits-1:0] x_end;
  logic [CoordBits-1:0] y_begin;
  logic [CoordBits-1:0] y_end;

  modport source (output valid, op, x_begin, x_end, y_begin, y_end, input ready);
  modport sink   (input valid, op, x_begin, x_end, y_begin, y_end, output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 pixel_valid;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;
  logic [3:0]           pixel_color;
  logic                 last_pixel;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  output ready);
endinterface

>>> rtl/dda_datapath.sv
// accumulators, pixel counter, serial dividers and pixel output register
module dda_datapath import dda_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dda_cmd_t             cmd_i,
  output dda_status_t          status_o,
  input  logic [CoordBits-1:0] x_begin_i,
  input  logic [CoordBits-1:0] x_end_i,
  input  logic [CoordBits-1:0] y_begin_i,
  input  logic [CoordBits-1:0] y_end_i,
  output logic [CoordBits-1:0] pixel_x_o,
  output logic [CoordBits-1:0] pixel_y_o,
  output logic [3:0]           pixel_color_o,
  output logic                 last_pixel_o
);

  localparam logic [AccBits-1:0] BiasFix = AccBits'(1) << (FracBits - 8);
  localparam logic [IncBits-1:0] OneFix  = IncBits'(1) << FracBits;

  // axis 0 is x, axis 1 is y
  logic [AccBits-1:0]    accum_q [2];
  logic [AccBits-1:0]    accum_d [2];
  logic [IncBits-1:0]    inc_q   [2];
  logic [IncBits-1:0]    inc_d   [2];
  logic [NumBits-1:0]    num_q   [2];
  logic [NumBits-1:0]    num_d   [2];
  logic [CoordBits:0]    rem_q   [2];
  logic [CoordBits:0]    rem_d   [2];
  logic                  neg_q   [2];
  logic                  neg_d   [2];
  logic [CoordBits:0]    trial   [2];
  logic                  fits    [2];
  logic [FracBits:0]     quot    [2];
  logic [CoordBits-1:0]  step_q, step_d;
  logic                  horiz_q, horiz_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [LeftBits-1:0]   left_q, left_d;
  logic [3:0]            color_q, color_d;
  logic                  busy_q, busy_d;
  logic [CoordBits-1:0]  pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [3:0]            pix_color_q, pix_color_d;
  logic                  pix_last_q, pix_last_d;

  logic                  xneg, yneg, horiz;
  logic [CoordBits-1:0]  adx, ady, step_len, x_start;

  assign xneg     = x_end_i < x_begin_i;
  assign yneg     = y_end_i < y_begin_i;
  assign adx      = xneg ? x_begin_i - x_end_i : x_end_i - x_begin_i;
  assign ady      = yneg ? y_begin_i - y_end_i : y_end_i - y_begin_i;
  assign horiz    = (ady == '0);
  assign step_len = (adx > ady) ? adx : ady;
  assign x_start  = (horiz && xneg) ? x_end_i : x_begin_i;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      accum_d[a] = accum_q[a];
      inc_d[a]   = inc_q[a];
      num_d[a]   = num_q[a];
      rem_d[a]   = rem_q[a];
      neg_d[a]   = neg_q[a];
      trial[a]   = {rem_q[a][CoordBits-1:0], num_q[a][NumBits-1]};
      fits[a]    = trial[a] >= {1'b0, step_q};
      quot[a]    = '0;
    end
    step_d      = step_q;
    horiz_d     = horiz_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    color_d     = color_q;
    busy_d      = busy_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_color_d = pix_color_q;
    pix_last_d  = pix_last_q;

    if (cmd_i.load_line) begin
      accum_d[0]  = {1'b0, x_start, FracBits'(0)} + BiasFix;
      accum_d[1]  = {1'b0, y_begin_i, FracBits'(0)} + BiasFix;
      neg_d[0]    = xneg;
      neg_d[1]    = yneg;
      num_d[0]    = {adx, FracBits'(0)};
      num_d[1]    = {ady, FracBits'(0)};
      rem_d[0]    = '0;
      rem_d[1]    = '0;
      step_d      = step_len;
      horiz_d     = horiz;
      cnt_d       = DivCntBits'(NumBits);
      left_d      = horiz ? {1'b0, adx} : {1'b0, step_len};
      color_d     = horiz ? ColorHoriz : ColorRest;
      if (horiz) begin
        inc_d[0] = OneFix;
        inc_d[1] = '0;
      end
      busy_d      = (left_d != '0);
      pix_x_d     = accum_d[0][FracBits +: CoordBits];
      pix_y_d     = accum_d[1][FracBits +: CoordBits];
      pix_color_d = horiz ? ColorHoriz : ColorFirst;
      pix_last_d  = (left_d == '0);
    end else if (cmd_i.step_px) begin
      for (int a = 0; a < 2; a++) begin
        accum_d[a] = accum_q[a]
                   + {{(AccBits - IncBits){inc_q[a][IncBits-1]}}, inc_q[a]};
      end
      left_d      = left_q - LeftBits'(1);
      busy_d      = (left_d != '0);
      pix_x_d     = accum_d[0][FracBits +: CoordBits];
      pix_y_d     = accum_d[1][FracBits +: CoordBits];
      pix_color_d = color_q;
      pix_last_d  = (left_d == '0);
    end else if (cmd_i.div_step) begin
      // one restoring division step per axis
      for (int a = 0; a < 2; a++) begin
        rem_d[a] = fits[a] ? trial[a] - {1'b0, step_q} : trial[a];
        num_d[a] = {num_q[a][NumBits-2:0], fits[a]};
        quot[a]  = num_d[a][FracBits:0];
        if ((cnt_q == DivCntBits'(1)) && !horiz_q) begin
          // round toward plus infinity
          inc_d[a] = neg_q[a] ? IncBits'(0) - {1'b0, quot[a]}
                              : {1'b0, quot[a]} + IncBits'(rem_d[a] != '0);
        end
      end
      cnt_d = cnt_q - DivCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 2; a++) begin
        accum_q[a] <= '0;
        inc_q[a]   <= '0;
      end
      left_q  <= '0;
      color_q <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      accum_q <= accum_d;
      inc_q   <= inc_d;
      left_q  <= left_d;
      color_q <= color_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q       <= num_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    step_q      <= step_d;
    horiz_q     <= horiz_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    pix_color_q <= pix_color_d;
    pix_last_q  <= pix_last_d;
  end

  assign status_o.busy     = busy_q;
  assign status_o.div_last = (cnt_q == DivCntBits'(1));
  assign pixel_x_o         = pix_x_q;
  assign pixel_y_o         = pix_y_q;
  assign pixel_color_o     = pix_color_q;
  assign last_pixel_o      = pix_last_q;

endmodule

>>> rtl/dda_ctrl.sv
// handshake control and division sequencing
`include "assert_macros.svh"
module dda_ctrl import dda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  op_e         in_op_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dda_status_t status_i,
  output dda_cmd_t    cmd_o
);

  typedef enum logic {
    S_READY,
    S_DIV
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == S_READY) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load_line = accept && (in_op_i == OP_START);
    cmd_o.step_px   = accept && (in_op_i == OP_STEP) && status_i.busy;
    cmd_o.div_step  = (state_q == S_DIV);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_READY;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_line || cmd_o.step_px) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_READY: begin
          if (cmd_o.load_line) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (status_i.div_last) begin
            state_q <= S_READY;
          end
        end
        default: begin
          state_q <= S_READY;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_no_accept_in_div, clk_i, rst_ni, (state_q == S_DIV) && in_ready_o, "input taken during division")
  `ASSERT_CLK(a_start_divides, clk_i, rst_ni, cmd_o.load_line |=> (state_q == S_DIV) && out_valid_q, "start did not begin division with first pixel")
  `ASSERT_CLK(a_div_ends, clk_i, rst_ni, (state_q == S_DIV) && status_i.div_last |=> (state_q == S_READY), "division did not finish")
  `ASSERT_CLK(a_step_emits, clk_i, rst_ni, cmd_o.step_px |=> out_valid_q, "step pixel not presented")

endmodule

>>> rtl/dda_line_pixel_generator.sv
// a pixel word is presented in the cycle after its input word is taken
// throughput: a step word every cycle while the pixel side keeps up and no division runs
// a start word holds the input off while two bit-serial dividers run, one bit per cycle
// step words while no line runs are taken and give no pixel
// reset (async, active low) clears accumulators, counters and state to idle
// top level: ties the channel interfaces to controller and datapath
module dda_line_pixel_generator import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  dda_in_if.sink   in_i,
  dda_out_if.source out_o
);

  dda_cmd_t    cmd;
  dda_status_t status;

  // controller: handshakes, output valid, division sequencing
  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: fixed point accumulators, increments, pixel register
  dda_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .x_begin_i     (in_i.x_begin),
    .x_end_i       (in_i.x_end),
    .y_begin_i     (in_i.y_begin),
    .y_end_i       (in_i.y_end),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .pixel_color_o (out_o.pixel_color),
    .last_pixel_o  (out_o.last_pixel)
  );

  // every presented word is a pixel
  assign out_o.pixel_valid = 1'b1;

endmodule
